// ----- hw/rtl/pow2_weight_bucket_switch_macros.svh -----
// Assertion macros used by the RTL of the bucket switch.
// Every check is sampled on the rising clock edge and is disabled while reset is high.
`ifndef POW2_WEIGHT_BUCKET_SWITCH_MACROS_SVH
`define POW2_WEIGHT_BUCKET_SWITCH_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every sampled edge.
`define PWBS_ASSERT_ALWAYS(label, clock, reset, expr, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PWBS_ASSERT_SAME(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PWBS_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PWBS_ASSERT_ALWAYS(label, clock, reset, expr, msg)
`define PWBS_ASSERT_SAME(label, clock, reset, ante, cons, msg)
`define PWBS_ASSERT_NEXT(label, clock, reset, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/pwbs_pkg.sv -----
package pwbs_pkg;

  // Depth of the switch counter store and the width of its address.
  localparam int ENTRIES = 4096;
  localparam int ADDR_W  = 12;

  // Each switch counter is a signed 9-bit value that saturates.
  localparam int CNT_W = 9;

  // Configuration registers: 32-bit data, byte address 4*i.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int THR_W      = 15;
  localparam int BAR_W      = 8;

  typedef enum logic [2:0] {
    REG_QUANT_THR = 3'd0,
    REG_GRAD_THR  = 3'd1,
    REG_SW_BAR    = 3'd2,
    REG_MIN_VAL   = 3'd3,
    REG_MAX_VAL   = 3'd4
  } reg_idx_t;

  localparam logic [THR_W-1:0] QUANT_THR_RST = 15'd20;
  localparam logic [THR_W-1:0] GRAD_THR_RST  = 15'd0;
  localparam logic [BAR_W-1:0] SW_BAR_RST    = 8'd3;
  localparam logic [THR_W-1:0] MIN_VAL_RST   = 15'd16;
  localparam logic [THR_W-1:0] MAX_VAL_RST   = 15'd32767;

endpackage

// ----- hw/rtl/pow2_weight_bucket_switch.sv -----
// Power-of-two weight quantizer with bucket switching. Each input word carries one
// coefficient, its gradient, its mask bit and its index. The coefficient is rounded to the
// nearer signed power of two (ties round up in magnitude), or to zero when its magnitude is
// below quant_threshold. The sign of the gradient (zero when its magnitude is at or below
// grad_threshold) is added to a saturating 9-bit counter selected by the index. When the
// counter magnitude equals bar_limit, a nonzero coefficient is doubled (counter sign agrees)
// or halved (counter sign disagrees), a zero coefficient with its mask bit set takes
// plus or minus min_value, the counter returns to zero, and switched is set in the output
// word. The result is clamped to plus or minus max_value. The block sustains one word per
// clock cycle while the output is not stalled; a result word passes the update stage
// register, which holds it while the output stalls, and then the output register. The
// rate is set by the counter memory: the counter is read in the cycle the word is accepted
// and written back when the word leaves the update stage, and a register of the last write
// forwards a counter that is still on its way into the memory. After reset the block zeroes
// the counter memory, one entry per cycle, with s_tready low; configuration writes are
// accepted throughout. Configuration must only be written while no word is in flight.
module pow2_weight_bucket_switch
  import pwbs_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata fields from bit 0 up: elem_index (12), coef_value (VALUE_BITS, signed),
  // grad_value (VALUE_BITS, signed), mask_bit (1), zero padding to whole bytes.
  input  logic [((2*VALUE_BITS+13+7)/8)*8-1:0] s_tdata,
  // Output stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata fields from bit 0 up: new_coef (VALUE_BITS, signed), switched (1),
  // zero padding to whole bytes.
  output logic [((VALUE_BITS+1+7)/8)*8-1:0] m_tdata,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  `include "pow2_weight_bucket_switch_macros.svh"

  localparam int OUT_W  = ((VALUE_BITS+1+7)/8)*8;
  // Width in which a magnitude and a threshold are compared.
  localparam int TW     = (VALUE_BITS > THR_W) ? VALUE_BITS : THR_W;
  // Width of a result magnitude: a doubled coefficient or a configured magnitude.
  localparam int MW     = (VALUE_BITS + 1 > THR_W) ? VALUE_BITS + 1 : THR_W;
  localparam int TOP_W  = $clog2(VALUE_BITS);
  localparam int COEF_LSB = ADDR_W;
  localparam int GRAD_LSB = ADDR_W + VALUE_BITS;
  localparam int MASK_BIT = ADDR_W + 2*VALUE_BITS;

  // ---------------------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------------------
  logic [THR_W-1:0] quant_threshold;
  logic [THR_W-1:0] grad_threshold;
  logic [BAR_W-1:0] bar_limit;
  logic [THR_W-1:0] min_value;
  logic [THR_W-1:0] max_value;
  logic             cfg_we;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_threshold <= QUANT_THR_RST;
      grad_threshold  <= GRAD_THR_RST;
      bar_limit       <= SW_BAR_RST;
      min_value       <= MIN_VAL_RST;
      max_value       <= MAX_VAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_QUANT_THR: quant_threshold <= pwdata[THR_W-1:0];
        REG_GRAD_THR:  grad_threshold  <= pwdata[THR_W-1:0];
        REG_SW_BAR:    bar_limit       <= pwdata[BAR_W-1:0];
        REG_MIN_VAL:   min_value       <= pwdata[THR_W-1:0];
        REG_MAX_VAL:   max_value       <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_QUANT_THR: prdata = CFG_DATA_W'(quant_threshold);
      REG_GRAD_THR:  prdata = CFG_DATA_W'(grad_threshold);
      REG_SW_BAR:    prdata = CFG_DATA_W'(bar_limit);
      REG_MIN_VAL:   prdata = CFG_DATA_W'(min_value);
      REG_MAX_VAL:   prdata = CFG_DATA_W'(max_value);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Clearing pass over the counter memory after reset.
  // ---------------------------------------------------------------------------------------
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(ENTRIES - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Accept stage: quantize the coefficient and classify the gradient while the counter
  // is read from memory.
  // ---------------------------------------------------------------------------------------
  logic                         in_accept;
  logic [ADDR_W-1:0]            in_idx;
  logic signed [VALUE_BITS-1:0] in_coef;
  logic signed [VALUE_BITS-1:0] in_grad;
  logic [VALUE_BITS-1:0]        cmag;
  logic [VALUE_BITS-1:0]        gmag;
  logic [TOP_W-1:0]             top;
  logic                         round_up;
  logic                         q_zero;
  logic [VALUE_BITS-1:0]        qmag;
  logic                         g_nz;

  assign in_idx  = s_tdata[ADDR_W-1:0];
  assign in_coef = s_tdata[COEF_LSB +: VALUE_BITS];
  assign in_grad = s_tdata[GRAD_LSB +: VALUE_BITS];

  // The most negative value keeps its own bit pattern, read as an unsigned magnitude.
  assign cmag = in_coef[VALUE_BITS-1] ? VALUE_BITS'(-in_coef) : VALUE_BITS'(in_coef);
  assign gmag = in_grad[VALUE_BITS-1] ? VALUE_BITS'(-in_grad) : VALUE_BITS'(in_grad);

  // Position of the leading one of the magnitude.
  always_comb begin
    top = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (cmag[i]) begin
        top = TOP_W'(i);
      end
    end
  end

  // The nearer power of two is the upper one exactly when the bit below the leading one is
  // set; a tie at one and a half lands there too.
  assign round_up = (top != '0) && cmag[top - 1'b1];
  assign q_zero   = (cmag == '0) || (TW'(cmag) < TW'(quant_threshold));

  always_comb begin
    qmag = VALUE_BITS'(1) << top;
    if (round_up) begin
      qmag = qmag << 1;
    end
    if (q_zero) begin
      qmag = '0;
    end
  end

  assign g_nz = TW'(gmag) > TW'(grad_threshold);

  // ---------------------------------------------------------------------------------------
  // Update stage registers.
  // ---------------------------------------------------------------------------------------
  logic                  s1_valid;
  logic [ADDR_W-1:0]     s1_idx;
  logic [VALUE_BITS-1:0] s1_qmag;
  logic                  s1_qneg;
  logic                  s1_up;
  logic                  s1_dn;
  logic                  s1_mask;
  logic                  s1_advance;

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !clr_active && (!s1_valid || s1_advance);
  assign in_accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_idx  <= in_idx;
      s1_qmag <= qmag;
      s1_qneg <= in_coef[VALUE_BITS-1];
      s1_up   <= g_nz && !in_grad[VALUE_BITS-1];
      s1_dn   <= g_nz && in_grad[VALUE_BITS-1];
      s1_mask <= s_tdata[MASK_BIT];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Counter memory. The read is issued when a word is accepted; the data is held while the
  // update stage waits for the output.
  // ---------------------------------------------------------------------------------------
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [CNT_W-1:0]        mem_wdata;
  logic [CNT_W-1:0]        mem_rdata;
  logic signed [CNT_W-1:0] wr_cnt;

  assign mem_we    = clr_active || s1_advance;
  assign mem_waddr = clr_active ? clr_addr : s1_idx;
  assign mem_wdata = clr_active ? '0 : wr_cnt;

  pwbs_ram #(
    .WIDTH (CNT_W),
    .DEPTH (ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (in_idx),
    .rdata (mem_rdata)
  );

  // The last counter written. A read at the same edge as that write returns the old entry,
  // so a match on the index takes the counter from here.
  logic                    fw_valid;
  logic [ADDR_W-1:0]       fw_idx;
  logic signed [CNT_W-1:0] fw_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (s1_advance) begin
      fw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      fw_idx <= s1_idx;
      fw_cnt <= wr_cnt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Update stage: counter step, switch decision, clamp.
  // ---------------------------------------------------------------------------------------
  logic signed [CNT_W-1:0] cur_cnt;
  logic signed [CNT_W:0]   cnt_sum;
  logic signed [CNT_W-1:0] cnt_sat;
  logic signed [CNT_W:0]   cnt_neg;
  logic [CNT_W-1:0]        cnt_mag;
  logic                    c_pos;
  logic                    c_neg;
  logic                    hit;
  logic [MW-1:0]           rmag;
  logic                    rneg;
  logic [MW-1:0]           cmag_lim;
  logic [MW:0]             res;

  assign cur_cnt = (fw_valid && (fw_idx == s1_idx)) ? fw_cnt : $signed(mem_rdata);

  always_comb begin
    cnt_sum = {cur_cnt[CNT_W-1], cur_cnt};
    if (s1_up) begin
      cnt_sum = cnt_sum + (CNT_W+1)'(1);
    end else if (s1_dn) begin
      cnt_sum = cnt_sum - (CNT_W+1)'(1);
    end
    // Saturate instead of wrapping at either end.
    if (cnt_sum[CNT_W] != cnt_sum[CNT_W-1]) begin
      cnt_sat = cnt_sum[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
    end else begin
      cnt_sat = cnt_sum[CNT_W-1:0];
    end
  end

  assign cnt_neg = -$signed({cnt_sat[CNT_W-1], cnt_sat});
  assign cnt_mag = cnt_sat[CNT_W-1] ? cnt_neg[CNT_W-1:0] : cnt_sat;
  assign c_neg   = cnt_sat[CNT_W-1];
  assign c_pos   = !cnt_sat[CNT_W-1] && (cnt_sat != '0);
  assign hit     = cnt_mag == CNT_W'(bar_limit);
  assign wr_cnt  = hit ? '0 : cnt_sat;

  always_comb begin
    rmag = MW'(s1_qmag);
    rneg = s1_qneg;
    if (hit) begin
      if (s1_qmag != '0) begin
        if ((c_pos && !s1_qneg) || (c_neg && s1_qneg)) begin
          rmag = MW'(s1_qmag) << 1;
        end else if ((c_pos && s1_qneg) || (c_neg && !s1_qneg)) begin
          rmag = MW'(s1_qmag) >> 1;
        end
      end else if (s1_mask) begin
        // A zero counter sign leaves the revived value at zero.
        rmag = (c_pos || c_neg) ? MW'(min_value) : '0;
        rneg = c_neg;
      end
    end
  end

  assign cmag_lim = (rmag > MW'(max_value)) ? MW'(max_value) : rmag;
  assign res      = rneg ? -{1'b0, cmag_lim} : {1'b0, cmag_lim};

  // ---------------------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tdata <= OUT_W'({hit, res[VALUE_BITS-1:0]});
    end
  end

  // ---------------------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------------------
  `PWBS_ASSERT_ALWAYS(a_no_write_clash, clk, rst, !(clr_active && s1_advance),
    "item write collides with the clearing pass")
  `PWBS_ASSERT_SAME(a_no_out_in_clear, clk, rst, clr_active, !m_tvalid && !s1_valid,
    "word in flight during the clearing pass")
  `PWBS_ASSERT_SAME(a_switch_clears, clk, rst, s1_advance && hit, wr_cnt == '0,
    "switch did not clear the counter")
  `PWBS_ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !s1_advance, s1_valid,
    "stalled update stage lost its word")
  `PWBS_ASSERT_NEXT(a_fw_tracks, clk, rst, s1_advance,
    fw_valid && fw_idx == $past(s1_idx) && fw_cnt == $past(wr_cnt),
    "forwarding register misses the last counter write")

endmodule

// ----- hw/rtl/pwbs_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module pwbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
